// ----- rtl/spq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int PRIO_W    = 16;
    localparam int DATA_W    = 32;
    localparam int MODE_W    = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_SPARE  = 2'd3
    } mode_t;

    // Shift commands broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;
        logic rem;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/sorted_priority_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Sorted priority queue of DEPTH entries, smallest priority at the head.
// Input channel (in_valid/in_ready) carries one word: mode, priority_req, data.
// Mode insert adds an entry behind all entries of equal or smaller priority,
// mode remove drops the head entry, mode query (and the spare code) only
// reports. Output channel (out_valid/out_ready) returns one word per input
// word: the head entry after the operation (zero fields when empty), the
// empty and full flags, and dropped for an insert refused on a full queue.
// The entries sit in a row of cells; every cell compares the new key with
// its own entry in parallel and shifts left or right with its neighbors, so
// an operation completes in the cycle it is accepted. The result word is
// valid in the cycle after acceptance. Throughput is one
// word per cycle while the receiver keeps out_ready high.
// When the receiver stalls, the result word holds and in_ready drops until
// the word is taken; a new word can enter in the same cycle it leaves.
// Reset empties the queue and clears out_valid; no clearing pass is needed.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           in_valid,
    output logic                          in_ready,
    input  wire logic [MODE_W-1:0]        mode,
    input  wire logic signed [PRIO_W-1:0] priority_req,
    input  wire logic signed [DATA_W-1:0] data,
    output logic                          out_valid,
    input  wire                           out_ready,
    output logic signed [PRIO_W-1:0]      head_priority,
    output logic signed [DATA_W-1:0]      head_data,
    output logic                          is_empty,
    output logic                          is_full,
    output logic                          dropped
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             dropped_reg;
    logic             dropped_next;

    logic             accept;
    logic             full;
    logic             empty;
    mode_t            op;
    cell_ctl_t        ctl;

    logic                     take_w [DEPTH];
    logic                     occ_w  [DEPTH];
    logic signed [PRIO_W-1:0] prio_w [DEPTH];
    logic signed [DATA_W-1:0] data_w [DEPTH];

    assign op     = mode_t'(mode);
    assign accept = in_valid && in_ready;
    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);

    // The queue only changes when a word is accepted, and a word is accepted
    // only when no result is pending or the previous result is leaving, so the
    // outputs can be read straight from the cells.
    assign in_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        ctl.ins        = 1'b0;
        ctl.rem        = 1'b0;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            out_valid_next = 1'b1;
            dropped_next   = 1'b0;
            case (op)
                MODE_INSERT:
                begin
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        ctl.ins    = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                MODE_REMOVE:
                begin
                    if (!empty)
                    begin
                        ctl.rem    = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            dropped_reg   <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            dropped_reg   <= dropped_next;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            assign occ_w[gi] = (count_reg > CNT_W'(gi));

            if (gi == 0)
            begin : g_first
                spq_cell u_cell (
                    .clk        (clk),
                    .ctl        (ctl),
                    .occupied   (occ_w[gi]),
                    .key        (priority_req),
                    .value      (data),
                    .left_take  (1'b0),
                    .left_prio  (priority_req),
                    .left_data  (data),
                    .right_prio (prio_w[gi+1]),
                    .right_data (data_w[gi+1]),
                    .take       (take_w[gi]),
                    .prio       (prio_w[gi]),
                    .data       (data_w[gi])
                );
            end
            else if (gi == DEPTH - 1)
            begin : g_last
                spq_cell u_cell (
                    .clk        (clk),
                    .ctl        (ctl),
                    .occupied   (occ_w[gi]),
                    .key        (priority_req),
                    .value      (data),
                    .left_take  (take_w[gi-1]),
                    .left_prio  (prio_w[gi-1]),
                    .left_data  (data_w[gi-1]),
                    .right_prio (prio_w[gi]),
                    .right_data (data_w[gi]),
                    .take       (take_w[gi]),
                    .prio       (prio_w[gi]),
                    .data       (data_w[gi])
                );
            end
            else
            begin : g_mid
                spq_cell u_cell (
                    .clk        (clk),
                    .ctl        (ctl),
                    .occupied   (occ_w[gi]),
                    .key        (priority_req),
                    .value      (data),
                    .left_take  (take_w[gi-1]),
                    .left_prio  (prio_w[gi-1]),
                    .left_data  (data_w[gi-1]),
                    .right_prio (prio_w[gi+1]),
                    .right_data (data_w[gi+1]),
                    .take       (take_w[gi]),
                    .prio       (prio_w[gi]),
                    .data       (data_w[gi])
                );
            end
        end
    endgenerate

    assign out_valid     = out_valid_reg;
    assign head_priority = empty ? '0 : prio_w[0];
    assign head_data     = empty ? '0 : data_w[0];
    assign is_empty      = empty;
    assign is_full       = full;
    assign dropped       = dropped_reg;

`ifndef SYNTHESIS
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_drop_full : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && dropped_reg |-> full)
        else $error("dropped reported on a queue that is not full");

    a_insert_grows : assert property (@(posedge clk) disable iff (!rst_n)
        accept && op == MODE_INSERT && !full |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not add an entry");

    a_remove_shrinks : assert property (@(posedge clk) disable iff (!rst_n)
        accept && op == MODE_REMOVE && !empty |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("remove did not take an entry");

    a_head_sorted : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= CNT_W'(2) |-> prio_w[0] <= prio_w[1])
        else $error("head entry out of order");

    // The head cell holds no defined entry while the queue is empty.
    a_hold_while_stalled : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> $stable(count_reg) && (empty || $stable(prio_w[0])))
        else $error("queue changed while a result was stalled");
`endif

endmodule

`default_nettype wire

// ----- rtl/spq_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire                      clk,
    input  wire cell_ctl_t           ctl,
    input  wire                      occupied,
    input  wire logic signed [PRIO_W-1:0] key,
    input  wire logic signed [DATA_W-1:0] value,
    input  wire                      left_take,
    input  wire logic signed [PRIO_W-1:0] left_prio,
    input  wire logic signed [DATA_W-1:0] left_data,
    input  wire logic signed [PRIO_W-1:0] right_prio,
    input  wire logic signed [DATA_W-1:0] right_data,
    output logic                     take,
    output logic signed [PRIO_W-1:0] prio,
    output logic signed [DATA_W-1:0] data
);

    logic signed [PRIO_W-1:0] prio_reg;
    logic signed [PRIO_W-1:0] prio_next;
    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    // A new key goes behind every entry of equal priority, so only a strictly
    // larger priority, or an empty slot, yields its place.
    assign take = !occupied || (key < prio_reg);

    always_comb
    begin
        prio_next = prio_reg;
        data_next = data_reg;
        if (ctl.ins && take)
        begin
            if (left_take)
            begin
                prio_next = left_prio;
                data_next = left_data;
            end
            else
            begin
                prio_next = key;
                data_next = value;
            end
        end
        else if (ctl.rem)
        begin
            prio_next = right_prio;
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        data_reg <= data_next;
    end

    assign prio = prio_reg;
    assign data = data_reg;

endmodule

`default_nettype wire

// ----- dv/spq_head_checker.sv -----
`timescale 1ns / 1ps

module spq_head_checker
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           in_valid,
    input  wire                           in_ready,
    input  wire logic [MODE_W-1:0]        mode,
    input  wire logic signed [PRIO_W-1:0] priority_req,
    input  wire logic signed [DATA_W-1:0] data,
    input  wire                           out_valid,
    input  wire                           out_ready,
    input  wire logic signed [PRIO_W-1:0] head_priority,
    input  wire logic signed [DATA_W-1:0] head_data,
    input  wire                           is_empty,
    input  wire                           is_full,
    input  wire                           dropped,
    output int                            outstanding,
    output int                            fail_count
);

    typedef struct {
        logic signed [PRIO_W-1:0] prio;
        logic signed [DATA_W-1:0] value;
        logic                     empty;
        logic                     full;
        logic                     drop;
    } head_word_t;

    // Shadow copy of the queue contents, kept sorted by ascending priority.
    logic signed [PRIO_W-1:0] shadow_prio[DEPTH];
    logic signed [DATA_W-1:0] shadow_data[DEPTH];
    int                       shadow_count;

    head_word_t expected_heads[$];
    int         mismatches;

    assign fail_count = mismatches;

    task automatic report_mismatch(input string what);
        mismatches++;
        // Keep the log short when the block is badly broken.
        if (mismatches <= 30)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    function automatic head_word_t apply_operation(input mode_t op,
                                                   input logic signed [PRIO_W-1:0] key,
                                                   input logic signed [DATA_W-1:0] value);
        head_word_t res;
        int         slot;
        res.drop = 1'b0;
        if (op == MODE_INSERT) begin
            if (shadow_count >= DEPTH) begin
                res.drop = 1'b1;
            end
            else begin
                // A new entry goes behind every entry of equal or smaller priority.
                slot = 0;
                while (slot < shadow_count && shadow_prio[slot] <= key)
                    slot++;
                for (int i = shadow_count; i > slot; i--) begin
                    shadow_prio[i] = shadow_prio[i-1];
                    shadow_data[i] = shadow_data[i-1];
                end
                shadow_prio[slot] = key;
                shadow_data[slot] = value;
                shadow_count++;
            end
        end
        else if (op == MODE_REMOVE && shadow_count > 0) begin
            for (int i = 1; i < shadow_count; i++) begin
                shadow_prio[i-1] = shadow_prio[i];
                shadow_data[i-1] = shadow_data[i];
            end
            shadow_count--;
        end
        res.empty = (shadow_count == 0);
        res.full  = (shadow_count >= DEPTH);
        res.prio  = res.empty ? '0 : shadow_prio[0];
        res.value = res.empty ? '0 : shadow_data[0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        head_word_t want;
        if (!rst_n)
        begin
            shadow_count = 0;
            expected_heads.delete();
            outstanding <= 0;
        end
        else
        begin
            // Results are compared before the new word is predicted, so a stray
            // result can never be matched against the word accepted with it.
            if (out_valid && out_ready)
            begin
                if (expected_heads.size() == 0)
                begin
                    report_mismatch("result word with no operation pending");
                end
                else
                begin
                    want = expected_heads.pop_front();
                    check_field("head_priority", longint'(head_priority), longint'(want.prio));
                    check_field("head_data", longint'(head_data), longint'(want.value));
                    check_field("is_empty", longint'(is_empty), longint'(want.empty));
                    check_field("is_full", longint'(is_full), longint'(want.full));
                    check_field("dropped", longint'(dropped), longint'(want.drop));
                end
            end
            if (in_valid && in_ready)
                expected_heads.push_back(apply_operation(mode_t'(mode), priority_req, data));
            outstanding <= expected_heads.size();
        end
    end

endmodule

// ----- dv/sorted_priority_queue_test.sv -----
`timescale 1ns / 1ps

module sorted_priority_queue_test;
    import spq_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int WORDS_PER_RUN = 370;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [MODE_W-1:0]        mode;
    logic signed [PRIO_W-1:0] priority_req;
    logic signed [DATA_W-1:0] data;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [PRIO_W-1:0] head_priority;
    logic signed [DATA_W-1:0] head_data;
    logic                     is_empty;
    logic                     is_full;
    logic                     dropped;
    int                       outstanding;
    int                       fail_count;

    int send_idle_pct;
    int recv_idle_pct;

    sorted_priority_queue #(.DEPTH(DEPTH)) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .priority_req  (priority_req),
        .data          (data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .head_priority (head_priority),
        .head_data     (head_data),
        .is_empty      (is_empty),
        .is_full       (is_full),
        .dropped       (dropped)
    );

    spq_head_checker #(.DEPTH(DEPTH)) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .priority_req  (priority_req),
        .data          (data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .head_priority (head_priority),
        .head_data     (head_data),
        .is_empty      (is_empty),
        .is_full       (is_full),
        .dropped       (dropped),
        .outstanding   (outstanding),
        .fail_count    (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Each call starts right after an edge, so in_valid gets exactly one
    // assignment per time step.
    task automatic send_word(input mode_t op,
                             input logic signed [PRIO_W-1:0] key,
                             input logic signed [DATA_W-1:0] value);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            mode         <= MODE_W'($urandom());
            priority_req <= PRIO_W'($urandom());
            data         <= $urandom();
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= op;
        priority_req <= key;
        data         <= value;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    function automatic logic signed [PRIO_W-1:0] pick_key();
        int roll;
        int v;
        roll = $urandom_range(0, 99);
        if (roll < 50)
        begin
            // A narrow band gives plenty of equal priorities.
            v = int'($urandom_range(0, 6)) - 3;
            return v[PRIO_W-1:0];
        end
        else if (roll < 62)
        begin
            case ($urandom_range(0, 3))
                0:       return 16'sh8000;
                1:       return 16'sh7fff;
                2:       return -16'sd1;
                default: return 16'sd0;
            endcase
        end
        return PRIO_W'($urandom());
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return 32'sh80000000;
            1:       return 32'sh7fffffff;
            default: return $urandom();
        endcase
    endfunction

    function automatic mode_t pick_mode(input int insert_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < insert_pct)
            return MODE_INSERT;
        else if (roll < 90)
            return MODE_REMOVE;
        else if (roll < 97)
            return MODE_QUERY;
        return MODE_SPARE;
    endfunction

    task automatic run_directed();
        send_word(MODE_QUERY, 16'sd7, 32'sd7);
        send_word(MODE_REMOVE, 16'sd0, 32'sd0);
        send_word(MODE_SPARE, 16'sh7fff, 32'sh7fffffff);
        send_word(MODE_INSERT, 16'sh7fff, 32'sh7fffffff);
        send_word(MODE_INSERT, 16'sh8000, 32'sh80000000);
        send_word(MODE_INSERT, 16'sh7fff, 32'sd1);
        send_word(MODE_INSERT, 16'sd0, -32'sd1);
        send_word(MODE_INSERT, -16'sd1, 32'sd0);
        // Equal priorities must come out in arrival order.
        for (int i = 0; i < DEPTH - 5; i++)
            send_word(MODE_INSERT, 16'sd5, 32'sd100 + i);
        send_word(MODE_INSERT, 16'sh8000, 32'sd55);
        send_word(MODE_QUERY, 16'sd0, 32'sd0);
        send_word(MODE_REMOVE, 16'sd0, 32'sd0);
        send_word(MODE_REMOVE, 16'sd0, 32'sd0);
    endtask

    // Mix filling, draining and balanced bursts, chosen at random, so that both
    // the full and the empty ends of the queue are visited many times.
    task automatic run_random(input int count);
        int sent;
        int burst;
        int insert_pct;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(10, 40);
            case ($urandom_range(0, 2))
                0:       insert_pct = 75;
                1:       insert_pct = 20;
                default: insert_pct = 45;
            endcase
            for (int i = 0; i < burst && sent < count; i++)
            begin
                send_word(pick_mode(insert_pct), pick_key(), pick_value());
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        send_idle_pct = 34;
        recv_idle_pct = 66;
        in_valid     <= 1'b0;
        mode         <= MODE_QUERY;
        priority_req <= '0;
        data         <= '0;
        out_ready    <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(WORDS_PER_RUN);
        send_idle_pct = 66;
        recv_idle_pct = 34;
        run_random(WORDS_PER_RUN);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(WORDS_PER_RUN);
        in_valid <= 1'b0;

        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("sorted_priority_queue_test OK");
        else
            $display("sorted_priority_queue_test NOT OK");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("sorted_priority_queue_test NOT OK");
        $finish;
    end

endmodule
